### rtl/core/ljpe_pkg.sv
// Shared types and constants for the Lennard-Jones pair energy block.
// Holds the beat structs, function and register codes and default sizes.
// No dependencies; every other file in rtl/core refers to it by scoped name.
`default_nettype none

package ljpe_pkg;

  localparam int MAX_ATOMS_DEF   = 4096;
  localparam int MAX_TYPES_DEF   = 64;
  localparam int BOND_SLOTS_DEF  = 4;
  localparam int ANGLE_SLOTS_DEF = 12;

  // Operand and product widths of the shared signed multiplier.
  localparam int MUL_W  = 33;
  localparam int PROD_W = 66;

  typedef enum logic [1:0] {
    FUNC_ATOM = 2'd0,
    FUNC_EXCL = 2'd1,
    FUNC_TYPE = 2'd2,
    FUNC_PAIR = 2'd3
  } func_e;

  localparam logic [1:0] CFG_BOX_X     = 2'd0;
  localparam logic [1:0] CFG_BOX_Y     = 2'd1;
  localparam logic [1:0] CFG_BOX_Z     = 2'd2;
  localparam logic [1:0] CFG_CUTOFF_SQ = 2'd3;

  typedef struct packed {
    func_e              func;
    logic [11:0]        atom_a;
    logic [11:0]        atom_b;
    logic [3:0]         slot;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
    logic signed [7:0]  image_x;
    logic signed [7:0]  image_y;
    logic signed [7:0]  image_z;
    logic [5:0]         atom_type;
    logic               flag;
  } in_item_t;

  typedef struct packed {
    logic signed [63:0] energy;
    logic [31:0]        pair_count;
    logic               saturated;
  } out_item_t;

  // Request to the divider: start pulse with Q32.32 numerator and denominator.
  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [63:0] den;
  } div_req_t;

endpackage

`default_nettype wire

### rtl/core/ljpe_mul.sv
// Shared signed 33x33 multiplier with a registered product.
// Depends on ljpe_pkg for the operand and product widths.
`default_nettype none

module ljpe_mul (
  input  logic                               clk_i,
  input  logic signed [ljpe_pkg::MUL_W-1:0]  a_i,
  input  logic signed [ljpe_pkg::MUL_W-1:0]  b_i,
  output logic signed [ljpe_pkg::PROD_W-1:0] prod_o
);

  logic signed [ljpe_pkg::PROD_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
  end

  assign prod_o = prod_q;

endmodule

`default_nettype wire

### rtl/core/ljpe_div.sv
// Radix-2 restoring divider producing floor(num * 2^32 / den) in 64 steps.
// The caller guarantees num[63:32] < den. Depends on ljpe_pkg for div_req_t.
`default_nettype none

module ljpe_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ljpe_pkg::div_req_t  req_i,
  output logic                done_o,
  output logic [63:0]         quo_o
);

  logic [63:0] rem_q, dvd_q, den_q, quo_q;
  logic [6:0]  cnt_q;
  logic        busy_q, done_q;
  logic [64:0] rem_sh;
  logic        take;

  assign rem_sh = {rem_q, dvd_q[63]};
  assign take   = rem_sh >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= 7'd64;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 7'd1;
        if (cnt_q == 7'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= {32'd0, req_i.num[63:32]};
      dvd_q <= {req_i.num[31:0], 32'd0};
      den_q <= req_i.den;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= take ? 64'(rem_sh - {1'b0, den_q}) : rem_sh[63:0];
      dvd_q <= {dvd_q[62:0], 1'b0};
      quo_q <= {quo_q[62:0], take};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

`default_nettype wire

### rtl/core/lennard_jones_pair_energy.sv
// Top level of the Lennard-Jones 12-6 pair energy accumulator.
// Uses ljpe_pkg, the shared multiplier ljpe_mul and the divider ljpe_div.
`default_nettype none

// The block holds atom records, bonded exclusions and per-type factors in
// on-chip memories and sums the 12-6 energy of the pairs that the host sends.
// Atom, exclusion and type loads each take one beat and leave the input
// ready. A pair rejected at the self, hydrogen or exclusion test skips the
// arithmetic; a counted pair walks through a small sequencer that uses one
// 33x33 multiplier for the image unwrap, the three squares, the epsilon and
// sigma products and five 64x64 fixed-point products built from four partial
// products each, and a radix-2 divider for the ratio sigma^2 / r^2. The input
// stall is high for the whole time a pair is at work. After reset the
// exclusion memory is cleared one atom row per cycle, so no input beat is
// taken until every row is cleared; configuration writes are taken at any
// time. The result of a pair marked last sits in an output register until it
// is taken, and the block keeps taking new beats meanwhile; only a second
// last pair waits for it.

module lennard_jones_pair_energy #(
  parameter int MAX_ATOMS   = ljpe_pkg::MAX_ATOMS_DEF,
  parameter int MAX_TYPES   = ljpe_pkg::MAX_TYPES_DEF,
  parameter int BOND_SLOTS  = ljpe_pkg::BOND_SLOTS_DEF,
  parameter int ANGLE_SLOTS = ljpe_pkg::ANGLE_SLOTS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  ljpe_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output ljpe_pkg::out_item_t  out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [1:0]           cfg_index_i,
  input  logic [47:0]          cfg_data_i
);

  localparam int EXCL = BOND_SLOTS + ANGLE_SLOTS;
  localparam int AW   = $clog2(MAX_ATOMS);
  localparam int TW   = (MAX_TYPES > 1) ? $clog2(MAX_TYPES) : 1;
  localparam int SW   = $clog2(EXCL);
  localparam int DW   = 44;

  localparam logic [4:0] ST_CLEAR = 5'd0;
  localparam logic [4:0] ST_IDLE  = 5'd1;
  localparam logic [4:0] ST_LDA   = 5'd2;
  localparam logic [4:0] ST_LDB   = 5'd3;
  localparam logic [4:0] ST_TFA   = 5'd4;
  localparam logic [4:0] ST_TFB   = 5'd5;
  localparam logic [4:0] ST_CHK   = 5'd6;
  localparam logic [4:0] ST_IMG   = 5'd7;
  localparam logic [4:0] ST_DLT   = 5'd8;
  localparam logic [4:0] ST_WRP   = 5'd9;
  localparam logic [4:0] ST_WRN   = 5'd10;
  localparam logic [4:0] ST_ABS   = 5'd11;
  localparam logic [4:0] ST_SQ    = 5'd12;
  localparam logic [4:0] ST_CUT   = 5'd13;
  localparam logic [4:0] ST_EPS   = 5'd14;
  localparam logic [4:0] ST_SIG   = 5'd15;
  localparam logic [4:0] ST_SIGR  = 5'd16;
  localparam logic [4:0] ST_MQ    = 5'd17;
  localparam logic [4:0] ST_DIV   = 5'd18;
  localparam logic [4:0] ST_MAG   = 5'd19;
  localparam logic [4:0] ST_ACC   = 5'd20;
  localparam logic [4:0] ST_ADD   = 5'd21;
  localparam logic [4:0] ST_FIN   = 5'd22;

  // Which 64x64 product the multiply sequence is working on.
  localparam logic [2:0] MQ_S2  = 3'd0;
  localparam logic [2:0] MQ_QQ  = 3'd1;
  localparam logic [2:0] MQ_Q3  = 3'd2;
  localparam logic [2:0] MQ_Q6  = 3'd3;
  localparam logic [2:0] MQ_TRM = 3'd4;

  typedef struct packed {
    logic [23:0]        img;
    logic               hyd;
    logic [5:0]         atype;
    logic signed [31:0] pz;
    logic signed [31:0] py;
    logic signed [31:0] px;
  } atom_rec_t;

  // Configuration registers.
  logic [30:0] box_x_q, box_y_q, box_z_q;
  logic [47:0] cutoff_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_x_q  <= 31'd655360;
      box_y_q  <= 31'd655360;
      box_z_q  <= 31'd655360;
      cutoff_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        ljpe_pkg::CFG_BOX_X:     box_x_q  <= cfg_data_i[30:0];
        ljpe_pkg::CFG_BOX_Y:     box_y_q  <= cfg_data_i[30:0];
        ljpe_pkg::CFG_BOX_Z:     box_z_q  <= cfg_data_i[30:0];
        ljpe_pkg::CFG_CUTOFF_SQ: cutoff_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [4:0] state_q, state_d;
  logic       in_acc;
  ljpe_pkg::in_item_t item_q;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  // ---------------------------------------------------------------------------
  // Memories. Loads are written straight from the accepted beat. Reads are
  // registered: the pair's first atom is read in the accept cycle, the second
  // atom in the cycle after.
  // ---------------------------------------------------------------------------
  atom_rec_t               atom_mem [MAX_ATOMS];
  logic [EXCL-1:0][12:0]   excl_mem [MAX_ATOMS];
  logic [63:0]             tf_mem   [MAX_TYPES];

  atom_rec_t             atm_rd_q, atm_a_q, atm_b_q;
  logic [EXCL-1:0][12:0] excl_rd_q;
  logic [63:0]           tf_rd_q;
  logic [AW-1:0]         rd_addr, wr_addr, clr_q;
  logic [TW-1:0]         tf_addr;
  logic                  in_a_ok, in_t_ok, atom_we, excl_we, tf_we;
  atom_rec_t             atom_wdata;

  assign in_a_ok = 32'(in_data_i.atom_a) < MAX_ATOMS;
  assign in_t_ok = 32'(in_data_i.atom_type) < MAX_TYPES;
  assign wr_addr = AW'(in_data_i.atom_a);
  assign atom_we = in_acc && (in_data_i.func == ljpe_pkg::FUNC_ATOM) && in_a_ok;
  assign excl_we = in_acc && (in_data_i.func == ljpe_pkg::FUNC_EXCL) && in_a_ok
                   && (32'(in_data_i.slot) < EXCL);
  assign tf_we   = in_acc && (in_data_i.func == ljpe_pkg::FUNC_TYPE) && in_t_ok;
  assign rd_addr = (state_q == ST_IDLE) ? AW'(in_data_i.atom_a) : AW'(item_q.atom_b);
  assign tf_addr = (state_q == ST_LDB) ? TW'(atm_a_q.atype) : TW'(atm_b_q.atype);

  always_comb begin
    atom_wdata.img   = {in_data_i.image_z, in_data_i.image_y, in_data_i.image_x};
    atom_wdata.hyd   = in_data_i.flag;
    atom_wdata.atype = in_data_i.atom_type;
    atom_wdata.pz    = in_data_i.coord_z;
    atom_wdata.py    = in_data_i.coord_y;
    atom_wdata.px    = in_data_i.coord_x;
  end

  always_ff @(posedge clk_i) begin
    if (atom_we) begin
      atom_mem[wr_addr] <= atom_wdata;
    end
    atm_rd_q <= atom_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_CLEAR) begin
      excl_mem[clr_q] <= '0;
    end else if (excl_we) begin
      excl_mem[wr_addr][SW'(in_data_i.slot)] <=
        in_data_i.flag ? {1'b1, in_data_i.atom_b} : 13'd0;
    end
    excl_rd_q <= excl_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (tf_we) begin
      tf_mem[TW'(in_data_i.atom_type)] <= {in_data_i.coord_y, in_data_i.coord_x};
    end
    tf_rd_q <= tf_mem[tf_addr];
  end

  // ---------------------------------------------------------------------------
  // Shared multiplier and divider.
  // ---------------------------------------------------------------------------
  logic signed [ljpe_pkg::MUL_W-1:0]  mul_a, mul_b;
  logic signed [ljpe_pkg::PROD_W-1:0] prod;
  ljpe_pkg::div_req_t                 div_req;
  logic                               div_done;
  logic [63:0]                        div_quo;

  ljpe_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  ljpe_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  // Datapath registers of the pair sequence.
  logic                 hit_q, rs_q, ts_q, eps_neg_q, neg_q;
  logic [63:0]          fac_a_q, fac_b_q, r2_q, emag_q, q_q, q3_q, q6_q, t_q;
  logic [1:0]           ax_q;
  logic signed [DW-1:0] d_q;
  logic [63:0]          mq_a_q, mq_b_q;
  logic [2:0]           mq_cnt_q, mq_sel_q;
  logic [127:0]         mq_acc_q;
  logic signed [63:0]   term_q;

  logic signed [63:0] energy_q;
  logic [31:0]        count_q;
  logic               sat_q;
  logic               out_valid_q;
  ljpe_pkg::out_item_t out_q;

  // Per-axis selection of positions, image counts and box length.
  logic signed [31:0] pos_a, pos_b;
  logic signed [7:0]  img_a, img_b;
  logic [30:0]        box_sel;

  always_comb begin
    case (ax_q)
      2'd0: begin
        pos_a = atm_a_q.px; pos_b = atm_b_q.px;
        img_a = atm_a_q.img[7:0]; img_b = atm_b_q.img[7:0];
        box_sel = box_x_q;
      end
      2'd1: begin
        pos_a = atm_a_q.py; pos_b = atm_b_q.py;
        img_a = atm_a_q.img[15:8]; img_b = atm_b_q.img[15:8];
        box_sel = box_y_q;
      end
      default: begin
        pos_a = atm_a_q.pz; pos_b = atm_b_q.pz;
        img_a = atm_a_q.img[23:16]; img_b = atm_b_q.img[23:16];
        box_sel = box_z_q;
      end
    endcase
  end

  logic signed [8:0]    img_df;
  logic signed [DW-1:0] pa_w, pb_w, pr_w, bx_w, d_abs;
  logic signed [DW:0]   d2, bx2;
  logic                 d_big;

  assign img_df = 9'(img_b) - 9'(img_a);
  assign pa_w   = DW'(pos_a);
  assign pb_w   = DW'(pos_b);
  assign pr_w   = prod[DW-1:0];
  assign bx_w   = DW'(box_sel);
  assign d2     = {d_q, 1'b0};
  assign bx2    = (DW+1)'(box_sel);
  assign d_abs  = d_q[DW-1] ? -d_q : d_q;
  assign d_big  = |d_abs[DW-1:32];

  // Pair rejection tests that need no arithmetic.
  logic hit, skip;

  always_comb begin
    hit = 1'b0;
    for (int s = 0; s < EXCL; s++) begin
      if (excl_rd_q[s][12] && (excl_rd_q[s][11:0] == item_q.atom_b)) begin
        hit = 1'b1;
      end
    end
  end

  assign skip = !(32'(item_q.atom_a) < MAX_ATOMS) || !(32'(item_q.atom_b) < MAX_ATOMS)
                || (item_q.atom_a == item_q.atom_b) || atm_a_q.hyd || atm_b_q.hyd
                || hit_q;

  // 64x64 Q32.32 product: four 32x32 partials, one per cycle, summed as the
  // registered products come back.
  logic [127:0] mq_add, mq_acc_d;
  logic [63:0]  mq_res;
  logic         mq_sat, mq_done, div_bad;

  always_comb begin
    case (mq_cnt_q)
      3'd1:    mq_add = {64'd0, prod[63:0]};
      3'd2:    mq_add = {32'd0, prod[63:0], 32'd0};
      3'd3:    mq_add = {32'd0, prod[63:0], 32'd0};
      3'd4:    mq_add = {prod[63:0], 64'd0};
      default: mq_add = '0;
    endcase
  end

  assign mq_acc_d = mq_acc_q + mq_add;
  assign mq_sat   = |mq_acc_d[127:96];
  assign mq_res   = mq_sat ? '1 : mq_acc_d[95:32];
  assign mq_done  = (state_q == ST_MQ) && (mq_cnt_q == 3'd4);
  // A zero distance or a ratio of 2^32 or more saturates the quotient.
  assign div_bad  = {32'd0, mq_res[63:32]} >= r2_q;

  assign div_req.start = mq_done && (mq_sel_q == MQ_S2) && !div_bad;
  assign div_req.num   = mq_res;
  assign div_req.den   = r2_q;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_IMG: begin
        mul_a = ljpe_pkg::MUL_W'(img_df);
        mul_b = {2'b00, box_sel};
      end
      ST_ABS: begin
        mul_a = {1'b0, d_abs[31:0]};
        mul_b = {1'b0, d_abs[31:0]};
      end
      ST_EPS: begin
        mul_a = ljpe_pkg::MUL_W'($signed(fac_a_q[31:0]));
        mul_b = ljpe_pkg::MUL_W'($signed(fac_b_q[31:0]));
      end
      ST_SIG: begin
        mul_a = ljpe_pkg::MUL_W'($signed(fac_a_q[63:32]));
        mul_b = ljpe_pkg::MUL_W'($signed(fac_b_q[63:32]));
      end
      ST_MQ: begin
        mul_a = {1'b0, (mq_cnt_q[1] ? mq_a_q[63:32] : mq_a_q[31:0])};
        mul_b = {1'b0, (mq_cnt_q[0] ? mq_b_q[63:32] : mq_b_q[31:0])};
      end
      default: ;
    endcase
  end

  // Magnitude of q6 - q3, forced to full scale when a ratio saturated.
  logic [63:0] mag_d;
  logic        neg_d;

  always_comb begin
    if (rs_q) begin
      mag_d = '1;
      neg_d = 1'b0;
    end else if (q6_q >= q3_q) begin
      mag_d = q6_q - q3_q;
      neg_d = 1'b0;
    end else begin
      mag_d = q3_q - q6_q;
      neg_d = 1'b1;
    end
  end

  // Doubling of the term with its limit, then the sign.
  logic        t_big;
  logic [63:0] t2;

  assign t_big = t_q > 64'h3FFF_FFFF_FFFF_FFFF;
  assign t2    = t_big ? 64'h7FFF_FFFF_FFFF_FFFF : {t_q[62:0], 1'b0};

  // Saturating energy sum.
  logic signed [64:0] e_sum;
  logic               e_ovf;

  assign e_sum = 65'(energy_q) + 65'(term_q);
  assign e_ovf = e_sum[64] != e_sum[63];

  logic [64:0] r2_sum;
  assign r2_sum = {1'b0, r2_q} + {1'b0, prod[63:0]};

  logic emit;
  assign emit = (state_q == ST_FIN) && item_q.flag && (!out_valid_q || !out_stall_i);

  // ---------------------------------------------------------------------------
  // Sequencer.
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: if (clr_q == AW'(MAX_ATOMS - 1)) state_d = ST_IDLE;
      ST_IDLE:  if (in_acc && (in_data_i.func == ljpe_pkg::FUNC_PAIR)) state_d = ST_LDA;
      ST_LDA:   state_d = ST_LDB;
      ST_LDB:   state_d = ST_TFA;
      ST_TFA:   state_d = ST_TFB;
      ST_TFB:   state_d = ST_CHK;
      ST_CHK:   state_d = skip ? ST_FIN : ST_IMG;
      ST_IMG:   state_d = ST_DLT;
      ST_DLT:   state_d = ST_WRP;
      ST_WRP:   state_d = ST_WRN;
      ST_WRN:   state_d = ST_ABS;
      ST_ABS:   state_d = d_big ? ST_FIN : ST_SQ;
      ST_SQ:    state_d = (ax_q == 2'd2) ? ST_CUT : ST_IMG;
      ST_CUT:   state_d = (r2_q < {cutoff_q, 16'd0}) ? ST_EPS : ST_FIN;
      ST_EPS:   state_d = ST_SIG;
      ST_SIG:   state_d = ST_SIGR;
      ST_SIGR:  state_d = ST_MQ;
      ST_MQ: begin
        if (mq_cnt_q == 3'd4) begin
          case (mq_sel_q)
            MQ_S2:   state_d = div_bad ? ST_MQ : ST_DIV;
            MQ_Q6:   state_d = ST_MAG;
            MQ_TRM:  state_d = ST_ACC;
            default: state_d = ST_MQ;
          endcase
        end
      end
      ST_DIV:   if (div_done) state_d = ST_MQ;
      ST_MAG:   state_d = ST_MQ;
      ST_ACC:   state_d = ST_ADD;
      ST_ADD:   state_d = ST_FIN;
      ST_FIN:   if (!item_q.flag || emit) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      energy_q    <= '0;
      count_q     <= '0;
      sat_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + AW'(1);
      end
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_CUT: begin
          if ((r2_q < {cutoff_q, 16'd0}) && (count_q != 32'hFFFF_FFFF)) begin
            count_q <= count_q + 32'd1;
          end
        end
        ST_MAG: if (rs_q) sat_q <= 1'b1;
        ST_ACC: if (ts_q || t_big) sat_q <= 1'b1;
        ST_ADD: begin
          if (e_ovf) begin
            energy_q <= e_sum[64] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
            sat_q    <= 1'b1;
          end else begin
            energy_q <= e_sum[63:0];
          end
        end
        ST_FIN: begin
          if (emit) begin
            out_valid_q <= 1'b1;
            energy_q    <= '0;
            count_q     <= '0;
            sat_q       <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q.energy     <= energy_q;
      out_q.pair_count <= count_q;
      out_q.saturated  <= sat_q;
    end
    case (state_q)
      ST_IDLE: if (in_acc) item_q <= in_data_i;
      ST_LDA: begin
        atm_a_q <= atm_rd_q;
        hit_q   <= hit;
      end
      ST_LDB: atm_b_q <= atm_rd_q;
      ST_TFA: fac_a_q <= (32'(atm_a_q.atype) < MAX_TYPES) ? tf_rd_q : '0;
      ST_TFB: fac_b_q <= (32'(atm_b_q.atype) < MAX_TYPES) ? tf_rd_q : '0;
      ST_CHK: begin
        r2_q <= '0;
        ax_q <= '0;
        rs_q <= 1'b0;
        ts_q <= 1'b0;
      end
      ST_DLT: d_q <= pb_w - pa_w - pr_w;
      ST_WRP: if (d2 > bx2) d_q <= d_q - bx_w;
      ST_WRN: if (d2 < -bx2) d_q <= d_q + bx_w;
      ST_SQ: begin
        r2_q <= r2_sum[64] ? '1 : r2_sum[63:0];
        ax_q <= ax_q + 2'd1;
      end
      ST_SIG: begin
        eps_neg_q <= prod[ljpe_pkg::PROD_W-1];
        emag_q    <= prod[ljpe_pkg::PROD_W-1] ? 64'(-prod) : prod[63:0];
      end
      ST_SIGR: begin
        mq_a_q   <= prod[ljpe_pkg::PROD_W-1] ? 64'(-prod) : prod[63:0];
        mq_b_q   <= prod[ljpe_pkg::PROD_W-1] ? 64'(-prod) : prod[63:0];
        mq_sel_q <= MQ_S2;
        mq_cnt_q <= '0;
        mq_acc_q <= '0;
      end
      ST_MQ: begin
        if (mq_cnt_q != 3'd4) begin
          mq_cnt_q <= mq_cnt_q + 3'd1;
          mq_acc_q <= mq_acc_d;
        end else begin
          mq_cnt_q <= '0;
          mq_acc_q <= '0;
          if (mq_sel_q == MQ_TRM) begin
            ts_q <= mq_sat;
          end else begin
            rs_q <= rs_q | mq_sat;
          end
          case (mq_sel_q)
            MQ_S2: begin
              if (div_bad) begin
                rs_q     <= 1'b1;
                q_q      <= '1;
                mq_a_q   <= '1;
                mq_b_q   <= '1;
                mq_sel_q <= MQ_QQ;
              end
            end
            MQ_QQ: begin
              mq_a_q   <= mq_res;
              mq_b_q   <= q_q;
              mq_sel_q <= MQ_Q3;
            end
            MQ_Q3: begin
              q3_q     <= mq_res;
              mq_a_q   <= mq_res;
              mq_b_q   <= mq_res;
              mq_sel_q <= MQ_Q6;
            end
            MQ_Q6:   q6_q <= mq_res;
            MQ_TRM:  t_q  <= mq_res;
            default: ;
          endcase
        end
      end
      ST_DIV: begin
        if (div_done) begin
          q_q      <= div_quo;
          mq_a_q   <= div_quo;
          mq_b_q   <= div_quo;
          mq_sel_q <= MQ_QQ;
        end
      end
      ST_MAG: begin
        neg_q    <= neg_d;
        mq_a_q   <= emag_q;
        mq_b_q   <= mag_d;
        mq_sel_q <= MQ_TRM;
      end
      ST_ACC: term_q <= (eps_neg_q != neg_q) ? -$signed(t2) : $signed(t2);
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

### rtl/core/ljpe_checker.sv
// Port-level checker for the Lennard-Jones pair energy block, with its bind.
// Depends on ljpe_pkg for the beat types and function codes.
`default_nettype none

module ljpe_checker (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_stall_o,
  input  ljpe_pkg::in_item_t   in_data_i,
  input  logic                 out_valid_o,
  input  logic                 out_stall_i,
  input  ljpe_pkg::out_item_t  out_data_o,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_o,
  input  logic [1:0]           cfg_index_i,
  input  logic [47:0]          cfg_data_i
);

  logic load_beat, pair_beat;

  assign load_beat = in_valid_i && !in_stall_o && (in_data_i.func != ljpe_pkg::FUNC_PAIR);
  assign pair_beat = in_valid_i && !in_stall_o && (in_data_i.func == ljpe_pkg::FUNC_PAIR);

  // A waiting result beat is held until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed while stalled");

  // Loads finish in the cycle they are taken.
  a_load_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_beat |=> !in_stall_o)
    else $error("load beat did not complete in one cycle");

  // A pair keeps the block busy for at least the cycle after it.
  a_pair_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pair_beat |=> in_stall_o)
    else $error("pair beat did not occupy the sequencer");

  // A new result only appears after the sequencer was busy with a pair.
  a_out_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result beat without pair work");

endmodule

bind lennard_jones_pair_energy ljpe_checker u_ljpe_checker (.*);

`default_nettype wire
